// ===== hdl/pdc_pkg.sv =====
// Shared constants, types and command codes for the PLL divider configuration calculator.
`default_nettype none
package pdc_pkg;

    localparam int unsigned WANT_W  = 20;
    localparam int unsigned REF_W   = 18;
    localparam int unsigned NUM_W   = 26;
    localparam int unsigned DIV_W   = 5;
    localparam int unsigned MUL_W   = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned RATE_W  = 26;
    localparam int unsigned CNT_W   = $clog2(NUM_W);

    localparam logic [12:0]       MIN_DIVIDED_KHZ = 13'd5000;
    localparam logic [DIV_W-1:0]  DIV_MAX         = 5'h1F;
    localparam logic [MUL_W-1:0]  MUL_MAX         = 8'hFF;
    localparam logic [RATE_W-1:0] RANGE3_KBPS     = 26'd501000;
    localparam logic [RATE_W-1:0] RANGE2_KBPS     = 26'd251000;
    localparam logic [RATE_W-1:0] RANGE1_KBPS     = 26'd126000;

    // divider operations
    localparam logic [1:0] OP_MUL = 2'd1;   // ceil(want * div / reference)
    localparam logic [1:0] OP_ACT = 2'd2;   // reference * mul / div, with a zero mul taken as 1

    typedef struct packed {
        logic       load_in;
        logic       start;
        logic [1:0] op;
        logic       latch_mul;
        logic       latch_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

    // reference / 5000, at least 1 and capped, by comparison against the multiples
    function automatic logic [DIV_W-1:0] pick_divider(input logic [REF_W-1:0] refclk);
        logic [DIV_W-1:0] d;
        d = DIV_W'(1);
        for (int k = 2; k <= int'(DIV_MAX); k++) begin
            if (refclk >= REF_W'(k * int'(MIN_DIVIDED_KHZ))) begin
                d = DIV_W'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [1:0] range_code(input logic [RATE_W-1:0] rate);
        logic [1:0] code;
        if (rate >= RANGE3_KBPS) begin
            code = 2'd3;
        end else if (rate >= RANGE2_KBPS) begin
            code = 2'd2;
        end else if (rate >= RANGE1_KBPS) begin
            code = 2'd1;
        end else begin
            code = 2'd0;
        end
        return code;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pdc_if.sv =====
// Valid/ready channel interfaces for the input and result items.
`default_nettype none
interface pdc_in_if;
    logic                        valid;
    logic                        ready;
    logic [pdc_pkg::WANT_W-1:0]  desired_rate_kbps;
    logic [pdc_pkg::REF_W-1:0]   reference_khz;

    modport source (output valid, output desired_rate_kbps, output reference_khz,
                    input ready);
    modport sink   (input valid, input desired_rate_kbps, input reference_khz,
                    output ready);
endinterface

interface pdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [pdc_pkg::WORD_W-1:0]  config_word;
    logic [pdc_pkg::RATE_W-1:0]  actual_rate_kbps;
    logic                        multiplier_clamped;

    modport source (output valid, output config_word, output actual_rate_kbps,
                    output multiplier_clamped, input ready);
    modport sink   (input valid, input config_word, input actual_rate_kbps,
                    input multiplier_clamped, output ready);
endinterface
`default_nettype wire

// ===== hdl/pdc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module pdc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [pdc_pkg::NUM_W-1:0]  i_num,
    input  wire logic [pdc_pkg::REF_W-1:0]  i_den,
    output logic      [pdc_pkg::NUM_W-1:0]  o_quo,
    output logic                            o_done
);
    import pdc_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [REF_W-1:0]  r_rem, n_rem;
    logic [REF_W-1:0]  r_den, n_den;

    logic [REF_W:0]    w_rem_sh;
    logic [REF_W:0]    w_diff;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[REF_W-1:0] : w_rem_sh[REF_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== hdl/pdc_dp.sv =====
// Datapath: operand registers, operand selection, divider and result registers.
`default_nettype none
module pdc_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pdc_pkg::t_cmd               i_cmd,
    input  wire logic [pdc_pkg::WANT_W-1:0]  i_want,
    input  wire logic [pdc_pkg::REF_W-1:0]   i_ref,
    output pdc_pkg::t_status                 o_status,
    output logic      [pdc_pkg::WORD_W-1:0]  o_config_word,
    output logic      [pdc_pkg::RATE_W-1:0]  o_actual_rate,
    output logic                             o_clamped
);
    import pdc_pkg::*;

    logic [WANT_W-1:0] r_want;
    logic [REF_W-1:0]  r_ref;
    logic [DIV_W-1:0]  r_div;
    logic [MUL_W-1:0]  r_mul;
    logic              r_clamped;
    logic [WORD_W-1:0] r_word;
    logic [RATE_W-1:0] r_actual;
    logic              r_out_clamped;

    logic [24:0]       w_prod_m;
    logic [NUM_W-1:0]  w_num_mul;
    logic [MUL_W-1:0]  w_dmul;
    logic [NUM_W-1:0]  w_prod_a;
    logic [NUM_W-1:0]  w_num;
    logic [REF_W-1:0]  w_den;
    logic [NUM_W-1:0]  w_quo;
    logic              w_done;
    logic [RATE_W-1:0] w_rate;

    assign w_prod_m  = {5'd0, r_want} * {20'd0, r_div};
    assign w_num_mul = {1'b0, w_prod_m} + {8'd0, r_ref} - 26'd1;
    assign w_dmul    = (r_mul == '0) ? 8'd1 : r_mul;
    assign w_prod_a  = {8'd0, r_ref} * {18'd0, w_dmul};

    always_comb begin
        case (i_cmd.op)
            OP_MUL: begin
                w_num = w_num_mul;
                w_den = r_ref;
            end
            OP_ACT: begin
                w_num = w_prod_a;
                w_den = {13'd0, r_div};
            end
            default: begin
                w_num = w_num_mul;
                w_den = r_ref;
            end
        endcase
    end

    pdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quo   (w_quo),
        .o_done  (w_done)
    );

    // a zero multiplier gives a zero rate for the range code
    assign w_rate = (r_mul == '0) ? '0 : w_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_want <= i_want;
            r_ref  <= i_ref;
            r_div  <= pick_divider(i_ref);
        end
        if (i_cmd.latch_mul) begin
            if (w_quo > NUM_W'(MUL_MAX)) begin
                r_mul     <= MUL_MAX;
                r_clamped <= 1'b1;
            end else begin
                r_mul     <= w_quo[MUL_W-1:0];
                r_clamped <= 1'b0;
            end
        end
        if (i_cmd.latch_out) begin
            r_word        <= {range_code(w_rate), 1'b0, r_div, r_mul};
            r_actual      <= w_quo;
            r_out_clamped <= r_clamped;
        end
    end

    assign o_status.div_done = w_done;
    assign o_config_word     = r_word;
    assign o_actual_rate     = r_actual;
    assign o_clamped         = r_out_clamped;

endmodule
`default_nettype wire

// ===== hdl/pdc_ctrl.sv =====
// Controller: sequences the two divisions and runs both handshakes.
`default_nettype none
module pdc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire pdc_pkg::t_status  i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output pdc_pkg::t_cmd          o_cmd
);
    import pdc_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL_GO   = 3'd1;
    localparam logic [2:0] S_MUL_WAIT = 3'd2;
    localparam logic [2:0] S_ACT_GO   = 3'd3;
    localparam logic [2:0] S_ACT_WAIT = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = OP_MUL;
                n_state     = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                o_cmd.op = OP_MUL;
                if (i_status.div_done) begin
                    o_cmd.latch_mul = 1'b1;
                    n_state         = S_ACT_GO;
                end
            end
            S_ACT_GO: begin
                o_cmd.start = 1'b1;
                o_cmd.op    = OP_ACT;
                n_state     = S_ACT_WAIT;
            end
            S_ACT_WAIT: begin
                o_cmd.op = OP_ACT;
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.op = OP_ACT;
                if (w_out_free) begin
                    o_cmd.latch_out = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hdl/pll_divider_config_calc.sv =====
// PLL divider configuration calculator, top level.
// Each item makes two passes through the shared 26-bit restoring divider, and the
// result is then loaded into the output register.
// A new item is accepted only once the previous one is in the output register; the next item
// is taken while the previous result still waits in the output register.
// Reset: synchronous, active low; clears the controller and divider control.
`default_nettype none
module pll_divider_config_calc (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pdc_in_if.sink     i_in,
    pdc_out_if.source  o_out
);
    import pdc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_out_valid;

    pdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    pdc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_want        (i_in.desired_rate_kbps),
        .i_ref         (i_in.reference_khz),
        .o_status      (w_status),
        .o_config_word (o_out.config_word),
        .o_actual_rate (o_out.actual_rate_kbps),
        .o_clamped     (o_out.multiplier_clamped)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in progress");

    a_clamp_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.multiplier_clamped) |-> (o_out.config_word[7:0] == MUL_MAX))
        else $error("clamped multiplier not at maximum");

    a_div_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.config_word[12:8] != 5'd0 && !o_out.config_word[13]))
        else $error("divider field zero or reserved bit set");

    a_zero_mul_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.config_word[7:0] == 8'd0) |-> (o_out.config_word[15:14] == 2'd0))
        else $error("zero multiplier with nonzero range code");

endmodule
`default_nettype wire
